[hw/rtl/zst_pkg.sv]
package zst_pkg;

    localparam int MAX_ITEMS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int SUM_W         = DATA_W + 2;
    localparam int MAX_TRIPLETS  = 63;
    localparam int TRIP_CNT_W    = 6;

    typedef enum logic {
        ALU_SUB,
        ALU_ADD3
    } alu_op_t;

    typedef struct packed {
        logic neg;
        logic zero;
    } alu_flags_t;

endpackage

[hw/rtl/zst_alu.sv]
module zst_alu (
    input  zst_pkg::alu_op_t                   op,
    input  logic signed [zst_pkg::DATA_W-1:0]  a,
    input  logic signed [zst_pkg::DATA_W-1:0]  b,
    input  logic signed [zst_pkg::DATA_W-1:0]  c,
    output zst_pkg::alu_flags_t                flags
);
    import zst_pkg::*;

    logic signed [SUM_W-1:0] a_ext;
    logic signed [SUM_W-1:0] b_ext;
    logic signed [SUM_W-1:0] c_ext;
    logic signed [SUM_W-1:0] result;

    assign a_ext = SUM_W'(a);
    assign b_ext = SUM_W'(b);
    assign c_ext = SUM_W'(c);

    always_comb
    begin
        unique case (op)
            ALU_ADD3: result = a_ext + b_ext + c_ext;
            ALU_SUB:  result = a_ext - b_ext;
            default:  result = a_ext - b_ext;
        endcase
    end

    assign flags.neg  = result[SUM_W-1];
    assign flags.zero = (result == '0);

endmodule

[hw/rtl/zero_sum_triplet_finder.sv]
// Load: one item per cycle while busy is low; a plain item gives no result.
// Run (after the item marked last, n stored): a selection sort of the store, then a
//   two-pointer search per anchor that skips equal anchors and equal neighbours after
//   each triplet, then the end item; with n below 3 only the end item is given.
// The run is paced by the store's one write port and two registered read ports.
// rst_n is asynchronous; it clears the sequencer, counters and result strobe.
module zero_sum_triplet_finder #(
    parameter int MAX_ITEMS = zst_pkg::MAX_ITEMS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [zst_pkg::DATA_W-1:0]  value,
    input  logic                               last_value,
    output logic                               strobe,
    output logic signed [zst_pkg::DATA_W-1:0]  first,
    output logic signed [zst_pkg::DATA_W-1:0]  second,
    output logic signed [zst_pkg::DATA_W-1:0]  third,
    output logic                               is_triplet,
    output logic                               none_found,
    output logic                               dropped,
    output logic                               last
);
    import zst_pkg::*;

    localparam int AW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int DEPTH = 1 << AW;
    localparam int CW    = $clog2(MAX_ITEMS + 1);
    localparam int XW    = CW + 2;

    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_SORT_INIT  = 4'd1;
    localparam logic [3:0] ST_SORT_FIRST = 4'd2;
    localparam logic [3:0] ST_SORT_SCAN  = 4'd3;
    localparam logic [3:0] ST_SWAP1      = 4'd4;
    localparam logic [3:0] ST_SWAP2      = 4'd5;
    localparam logic [3:0] ST_ANCH       = 4'd6;
    localparam logic [3:0] ST_ANCH2      = 4'd7;
    localparam logic [3:0] ST_PAIR_RD    = 4'd8;
    localparam logic [3:0] ST_EVAL       = 4'd9;
    localparam logic [3:0] ST_SKL_RD     = 4'd10;
    localparam logic [3:0] ST_SKL_CMP    = 4'd11;
    localparam logic [3:0] ST_SKH_RD     = 4'd12;
    localparam logic [3:0] ST_SKH_CMP    = 4'd13;
    localparam logic [3:0] ST_STEP       = 4'd14;
    localparam logic [3:0] ST_END        = 4'd15;

    logic signed [DATA_W-1:0] store [0:DEPTH-1];

    logic [3:0]            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  ovf_reg, ovf_next;
    logic                  found_reg, found_next;
    logic [TRIP_CNT_W-1:0] trip_cnt_reg, trip_cnt_next;
    logic [CW-1:0]         i_reg, i_next;
    logic [CW-1:0]         j_reg, j_next;
    logic [CW-1:0]         m_reg, m_next;
    logic [CW-1:0]         lo_reg, lo_next;
    logic [CW-1:0]         hi_reg, hi_next;
    logic signed [DATA_W-1:0] ival_reg, ival_next;
    logic signed [DATA_W-1:0] mval_reg, mval_next;
    logic signed [DATA_W-1:0] aval_reg, aval_next;
    logic signed [DATA_W-1:0] prev_reg, prev_next;
    logic signed [DATA_W-1:0] lval_reg, lval_next;
    logic signed [DATA_W-1:0] hval_reg, hval_next;
    logic signed [DATA_W-1:0] rd_a_reg, rd_b_reg;

    logic                  strobe_reg, strobe_next;
    logic signed [DATA_W-1:0] first_reg, first_next;
    logic signed [DATA_W-1:0] second_reg, second_next;
    logic signed [DATA_W-1:0] third_reg, third_next;
    logic                  trip_reg, trip_next;
    logic                  none_reg, none_next;
    logic                  drop_reg, drop_next;
    logic                  last_reg, last_next;

    logic                  we;
    logic [AW-1:0]         waddr;
    logic signed [DATA_W-1:0] wdata;
    logic [AW-1:0]         raddr_a, raddr_b;

    alu_op_t               alu_op;
    logic signed [DATA_W-1:0] alu_a, alu_b, alu_c;
    alu_flags_t            alu_flags;

    logic [XW-1:0]         n_x, i_x, j_x, lo_x, hi_x;
    logic [CW-1:0]         cnt_new;
    logic                  more_anchor;

    zst_alu u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .c     (alu_c),
        .flags (alu_flags)
    );

    assign n_x  = XW'(count_reg);
    assign i_x  = XW'(i_reg);
    assign j_x  = XW'(j_reg);
    assign lo_x = XW'(lo_reg);
    assign hi_x = XW'(hi_reg);
    assign more_anchor = (i_x + XW'(3)) < n_x;
    assign cnt_new = (count_reg < CW'(MAX_ITEMS)) ? count_reg + CW'(1) : count_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store[waddr] <= wdata;
        end
        rd_a_reg <= store[raddr_a];
        rd_b_reg <= store[raddr_b];
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        found_next    = found_reg;
        trip_cnt_next = trip_cnt_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        m_next        = m_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        ival_next     = ival_reg;
        mval_next     = mval_reg;
        aval_next     = aval_reg;
        prev_next     = prev_reg;
        lval_next     = lval_reg;
        hval_next     = hval_reg;
        strobe_next   = 1'b0;
        first_next    = first_reg;
        second_next   = second_reg;
        third_next    = third_reg;
        trip_next     = trip_reg;
        none_next     = none_reg;
        drop_next     = drop_reg;
        last_next     = last_reg;
        we            = 1'b0;
        waddr         = i_reg[AW-1:0];
        wdata         = value;
        raddr_a       = i_reg[AW-1:0];
        raddr_b       = hi_reg[AW-1:0];
        alu_op        = ALU_SUB;
        alu_a         = rd_a_reg;
        alu_b         = mval_reg;
        alu_c         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (count_reg < CW'(MAX_ITEMS))
                    begin
                        we         = 1'b1;
                        waddr      = count_reg[AW-1:0];
                        wdata      = value;
                        count_next = cnt_new;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_value)
                    begin
                        i_next = '0;
                        if (XW'(cnt_new) >= XW'(3))
                        begin
                            state_next = ST_SORT_INIT;
                        end
                        else
                        begin
                            state_next = ST_END;
                        end
                    end
                end
            end
            ST_SORT_INIT:
            begin
                raddr_a    = i_reg[AW-1:0];
                state_next = ST_SORT_FIRST;
            end
            ST_SORT_FIRST:
            begin
                ival_next  = rd_a_reg;
                mval_next  = rd_a_reg;
                m_next     = i_reg;
                j_next     = i_reg + CW'(1);
                raddr_a    = j_next[AW-1:0];
                state_next = ST_SORT_SCAN;
            end
            ST_SORT_SCAN:
            begin
                alu_op = ALU_SUB;
                alu_a  = rd_a_reg;
                alu_b  = mval_reg;
                if (alu_flags.neg)
                begin
                    m_next    = j_reg;
                    mval_next = rd_a_reg;
                end
                j_next  = j_reg + CW'(1);
                raddr_a = j_next[AW-1:0];
                if ((j_x + XW'(1)) >= n_x)
                begin
                    state_next = ST_SWAP1;
                end
            end
            ST_SWAP1:
            begin
                we         = 1'b1;
                waddr      = i_reg[AW-1:0];
                wdata      = mval_reg;
                state_next = ST_SWAP2;
            end
            ST_SWAP2:
            begin
                we    = 1'b1;
                waddr = m_reg[AW-1:0];
                wdata = ival_reg;
                if ((i_x + XW'(2)) < n_x)
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = ST_SORT_INIT;
                end
                else
                begin
                    i_next     = '0;
                    state_next = ST_ANCH;
                end
            end
            ST_ANCH:
            begin
                raddr_a    = i_reg[AW-1:0];
                state_next = ST_ANCH2;
            end
            ST_ANCH2:
            begin
                alu_op    = ALU_SUB;
                alu_a     = rd_a_reg;
                alu_b     = prev_reg;
                prev_next = rd_a_reg;
                if ((i_reg != '0) && alu_flags.zero)
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = more_anchor ? ST_ANCH : ST_END;
                end
                else
                begin
                    aval_next  = rd_a_reg;
                    lo_next    = i_reg + CW'(1);
                    hi_next    = count_reg - CW'(1);
                    state_next = ST_PAIR_RD;
                end
            end
            ST_PAIR_RD:
            begin
                raddr_a    = lo_reg[AW-1:0];
                raddr_b    = hi_reg[AW-1:0];
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                alu_op = ALU_ADD3;
                alu_a  = aval_reg;
                alu_b  = rd_a_reg;
                alu_c  = rd_b_reg;
                if (alu_flags.zero)
                begin
                    strobe_next   = 1'b1;
                    first_next    = aval_reg;
                    second_next   = rd_a_reg;
                    third_next    = rd_b_reg;
                    trip_next     = 1'b1;
                    none_next     = 1'b0;
                    drop_next     = 1'b0;
                    last_next     = 1'b0;
                    found_next    = 1'b1;
                    trip_cnt_next = trip_cnt_reg + TRIP_CNT_W'(1);
                    lval_next     = rd_a_reg;
                    hval_next     = rd_b_reg;
                    if (trip_cnt_reg == TRIP_CNT_W'(MAX_TRIPLETS - 1))
                    begin
                        state_next = ST_END;
                    end
                    else
                    begin
                        state_next = ST_SKL_RD;
                    end
                end
                else if (alu_flags.neg)
                begin
                    lo_next = lo_reg + CW'(1);
                    if ((lo_x + XW'(1)) < hi_x)
                    begin
                        state_next = ST_PAIR_RD;
                    end
                    else
                    begin
                        i_next     = i_reg + CW'(1);
                        state_next = more_anchor ? ST_ANCH : ST_END;
                    end
                end
                else
                begin
                    hi_next = hi_reg - CW'(1);
                    if ((lo_x + XW'(1)) < hi_x)
                    begin
                        state_next = ST_PAIR_RD;
                    end
                    else
                    begin
                        i_next     = i_reg + CW'(1);
                        state_next = more_anchor ? ST_ANCH : ST_END;
                    end
                end
            end
            ST_SKL_RD:
            begin
                raddr_a = lo_next[AW-1:0] + AW'(1);
                if (lo_reg < hi_reg)
                begin
                    state_next = ST_SKL_CMP;
                end
                else
                begin
                    state_next = ST_SKH_RD;
                end
            end
            ST_SKL_CMP:
            begin
                alu_op = ALU_SUB;
                alu_a  = rd_a_reg;
                alu_b  = lval_reg;
                if (alu_flags.zero)
                begin
                    lo_next    = lo_reg + CW'(1);
                    state_next = ST_SKL_RD;
                end
                else
                begin
                    state_next = ST_SKH_RD;
                end
            end
            ST_SKH_RD:
            begin
                raddr_b = hi_reg[AW-1:0] - AW'(1);
                if (lo_reg < hi_reg)
                begin
                    state_next = ST_SKH_CMP;
                end
                else
                begin
                    state_next = ST_STEP;
                end
            end
            ST_SKH_CMP:
            begin
                alu_op = ALU_SUB;
                alu_a  = rd_b_reg;
                alu_b  = hval_reg;
                if (alu_flags.zero)
                begin
                    hi_next    = hi_reg - CW'(1);
                    state_next = ST_SKH_RD;
                end
                else
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                lo_next = lo_reg + CW'(1);
                hi_next = hi_reg - CW'(1);
                if ((lo_x + XW'(2)) < hi_x)
                begin
                    state_next = ST_PAIR_RD;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = more_anchor ? ST_ANCH : ST_END;
                end
            end
            ST_END:
            begin
                strobe_next   = 1'b1;
                first_next    = '0;
                second_next   = '0;
                third_next    = '0;
                trip_next     = 1'b0;
                none_next     = ~found_reg;
                drop_next     = ovf_reg;
                last_next     = 1'b1;
                count_next    = '0;
                ovf_next      = 1'b0;
                found_next    = 1'b0;
                trip_cnt_next = '0;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            found_reg    <= 1'b0;
            trip_cnt_reg <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            found_reg    <= found_next;
            trip_cnt_reg <= trip_cnt_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        m_reg      <= m_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        ival_reg   <= ival_next;
        mval_reg   <= mval_next;
        aval_reg   <= aval_next;
        prev_reg   <= prev_next;
        lval_reg   <= lval_next;
        hval_reg   <= hval_next;
        first_reg  <= first_next;
        second_reg <= second_next;
        third_reg  <= third_next;
        trip_reg   <= trip_next;
        none_reg   <= none_next;
        drop_reg   <= drop_next;
        last_reg   <= last_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign strobe     = strobe_reg;
    assign first      = first_reg;
    assign second     = second_reg;
    assign third      = third_reg;
    assign is_triplet = trip_reg;
    assign none_found = none_reg;
    assign dropped    = drop_reg;
    assign last       = last_reg;

endmodule

[hw/rtl/zst_checker.sv]
module zst_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               last_value,
    input logic                               strobe,
    input logic signed [zst_pkg::DATA_W-1:0]  first,
    input logic signed [zst_pkg::DATA_W-1:0]  second,
    input logic signed [zst_pkg::DATA_W-1:0]  third,
    input logic                               is_triplet,
    input logic                               none_found,
    input logic                               dropped,
    input logic                               last
);
    import zst_pkg::*;

    logic signed [SUM_W-1:0] trip_sum;

    assign trip_sum = SUM_W'(first) + SUM_W'(second) + SUM_W'(third);

    // a triplet item is ordered and sums to zero
    a_trip_ok: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && is_triplet |-> (first <= second) && (second <= third) && (trip_sum == '0))
        else $error("triplet item not ordered or not zero-sum");

    a_trip_flags: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && is_triplet |-> !last && !none_found && !dropped)
        else $error("triplet item carries end flags");

    a_end_item: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !is_triplet |-> last && (first == '0) && (second == '0) && (third == '0))
        else $error("end item malformed");

    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> !busy)
        else $error("block still busy while end item shown");

    a_plain_load: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !last_value |=> !busy && !strobe)
        else $error("plain item started a run");

endmodule

bind zero_sum_triplet_finder zst_checker u_zst_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .last_value (last_value),
    .strobe     (strobe),
    .first      (first),
    .second     (second),
    .third      (third),
    .is_triplet (is_triplet),
    .none_found (none_found),
    .dropped    (dropped),
    .last       (last)
);
